FILE: rtl/efc_pkg.sv
// shared types and constants of the effective frequency block
package efc_pkg;

  localparam int unsigned NUM_CPUS_DEF = 16;

  localparam int unsigned CPU_W    = 4;
  localparam int unsigned COUNT_W  = 64;
  localparam int unsigned HALF_W   = COUNT_W / 2;
  localparam int unsigned TSC_W    = 34;
  localparam int unsigned FREQ_W   = 20;

  localparam logic [TSC_W-1:0] TSC_RESET = TSC_W'(64'd1000000000);

  // timestamp scaling: tsc_freq_hz / 100 as ((tsc_freq_hz >> 2) * m) >> 35
  localparam int unsigned SCALE_DIV    = 100;
  localparam int unsigned SCALE_W      = 28;
  localparam int unsigned SCALE_PRE    = 2;
  localparam int unsigned SCALE_SHIFT  = 35;
  localparam int unsigned SCALE_PROD_W = SCALE_SHIFT + SCALE_W;
  localparam logic [TSC_W-SCALE_PRE-1:0] SCALE_MAGIC = 32'h51EB_851F;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(TSC_RESET / SCALE_DIV);

  // final divide by 10000, folded into the denominator
  localparam int unsigned FREQ_DIV   = 10000;
  localparam int unsigned FREQ_DIV_W = $clog2(FREQ_DIV);

  localparam int unsigned PROD_W     = COUNT_W + SCALE_W;
  localparam int unsigned DEN_W      = COUNT_W + FREQ_DIV_W;
  localparam int unsigned DV_W       = DEN_W + FREQ_W;
  localparam int unsigned QUOT_STEPS = FREQ_W + 1;
  localparam int unsigned STEP_W     = $clog2(QUOT_STEPS);

  localparam logic OP_PRIME  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0] prev_actual;
    logic [COUNT_W-1:0] prev_reference;
    logic [COUNT_W-1:0] actual_delta;
    logic [COUNT_W-1:0] reference_delta;
  } entry_t;

  typedef struct packed {
    logic               busy;
    logic [SCALE_W-1:0] value;
  } scale_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL0,
    ST_MUL1,
    ST_QUOT,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/efc_in_if.sv
// sample channel: valid/ready with operation, cpu and counter samples
interface efc_in_if;
  import efc_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [CPU_W-1:0]   cpu_index;
  logic [COUNT_W-1:0] actual_count;
  logic [COUNT_W-1:0] reference_count;

  modport source (
    output valid, operation, cpu_index, actual_count, reference_count,
    input  ready
  );
  modport sink (
    input  valid, operation, cpu_index, actual_count, reference_count,
    output ready
  );
endinterface

FILE: rtl/efc_out_if.sv
// result channel: valid/ready with cpu, frequency and saturation flag
interface efc_out_if;
  import efc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CPU_W-1:0]  cpu_out;
  logic [FREQ_W-1:0] freq_mhz;
  logic              saturated;

  modport source (
    output valid, cpu_out, freq_mhz, saturated,
    input  ready
  );
  modport sink (
    input  valid, cpu_out, freq_mhz, saturated,
    output ready
  );
endinterface

FILE: rtl/efc_ram.sv
// generic single-write, single-read ram with registered read data
module efc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/efc_scale.sv
// reciprocal-multiply scaling of the timestamp frequency by 1/100 after each config write
module efc_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [efc_pkg::TSC_W-1:0]   cfg_wdata,
  output efc_pkg::scale_status_t      status
);
  import efc_pkg::*;

  logic                          busy;
  logic [TSC_W-SCALE_PRE-1:0]    num;
  logic [SCALE_W-1:0]            quot;
  logic [SCALE_PROD_W-1:0]       prod;

  // n / 4 then / 25 by rounded-up reciprocal, exact for every 32-bit n / 4
  assign prod = SCALE_PROD_W'(num) * SCALE_PROD_W'(SCALE_MAGIC);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      quot <= SCALE_RESET;
    end else if (cfg_we) begin
      busy <= 1'b1;
    end else if (busy) begin
      quot <= prod[SCALE_PROD_W-1:SCALE_SHIFT];
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      num <= cfg_wdata[TSC_W-1:SCALE_PRE];
    end
  end

  assign status = '{busy: busy, value: quot};

endmodule

FILE: rtl/effective_freq_from_counters.sv
// effective cpu frequency from per-cpu actual and reference cycle counters
//
// samples (sink): one word names a cpu and carries raw actual and reference
// counter samples. operation prime only records them as previous values;
// operation update refreshes the deltas when both counters grew, records
// the samples and returns one result word on the result channel.
// result (source): cpu_out, freq_mhz, saturated, held until taken.
// cfg_we/cfg_wdata write tsc_freq_hz; while the scale by 1/100 is then
// computed, samples.ready stays low.
// per-cpu state lives in one ram (prev samples and deltas, read-modify-
// write); a valid bit per cpu makes a never-written entry read as zero.
// a prime word passes ram read and write back. an update word passes
// delta update, two 32-bit multiply steps, 21 steps of the serial quotient
// unit and result load, which raises result.valid. the next word is
// accepted only once the result is loaded and the state is back in idle.
// a stalled receiver holds the finished result in the output register; the
// next word is still accepted and computed, waiting only at result load.
// reset (synchronous) clears all cpu state and sets tsc_freq_hz to 1 GHz.
// a word whose cpu index is not below NUM_CPUS is accepted and dropped.
module effective_freq_from_counters #(
  parameter int unsigned NUM_CPUS = efc_pkg::NUM_CPUS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  efc_in_if.sink                    samples,
  efc_out_if.source                 result,
  input  logic                      cfg_we,
  input  logic [efc_pkg::TSC_W-1:0] cfg_wdata
);
  import efc_pkg::*;

  localparam int unsigned AW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  state_t state, state_next;
  scale_status_t scale_st;

  logic                accept;
  logic                cpu_ok;
  logic [AW-1:0]       raddr;
  logic [NUM_CPUS-1:0] entry_valid;

  logic                op_q;
  logic [CPU_W-1:0]    cpu_q;
  logic [AW-1:0]       addr_q;
  logic [COUNT_W-1:0]  act_q;
  logic [COUNT_W-1:0]  ref_q;
  logic                hit;

  logic [$bits(entry_t)-1:0] ram_rdata;
  logic                      ram_we;
  entry_t                    ram_wdata;
  entry_t                    cur;

  logic                grow;
  logic [COUNT_W-1:0]  da_upd;
  logic [COUNT_W-1:0]  dr_upd;
  logic [COUNT_W-1:0]  da_q;
  logic [COUNT_W-1:0]  dr_q;

  logic [HALF_W-1:0]            mul_a;
  logic [HALF_W-1:0]            mul_d;
  logic [HALF_W+SCALE_W-1:0]    pa;
  logic [HALF_W+FREQ_DIV_W-1:0] pd;

  logic [PROD_W-1:0]     prod;
  logic [DEN_W-1:0]      den;
  logic [PROD_W-1:0]     rem;
  logic [DV_W-1:0]       dv;
  logic [QUOT_STEPS-1:0] q;
  logic [STEP_W-1:0]     step;
  logic                  ge;

  logic              out_valid;
  logic              out_free;
  logic [CPU_W-1:0]  out_cpu;
  logic [FREQ_W-1:0] out_freq;
  logic              out_sat;

  efc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .status    (scale_st)
  );

  efc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_CPUS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_q),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign samples.ready = (state == ST_IDLE) && !scale_st.busy;
  assign accept        = samples.valid && samples.ready;
  assign cpu_ok        = (32'(samples.cpu_index) < NUM_CPUS);
  assign raddr         = AW'(samples.cpu_index);
  assign out_free      = !out_valid || result.ready;

  // delta update on the entry just read
  always_comb begin
    cur    = hit ? entry_t'(ram_rdata) : '0;
    grow   = (act_q > cur.prev_actual) && (ref_q > cur.prev_reference);
    da_upd = grow ? (act_q - cur.prev_actual) : cur.actual_delta;
    dr_upd = grow ? (ref_q - cur.prev_reference) : cur.reference_delta;
    if (dr_upd == '0) begin
      dr_upd = COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_wdata.prev_actual    = act_q;
    ram_wdata.prev_reference = ref_q;
    ram_wdata.actual_delta   = cur.actual_delta;
    ram_wdata.reference_delta = cur.reference_delta;
    case (state)
      ST_IDLE: begin
        if (accept && cpu_ok) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        ram_we = 1'b1;
        if (op_q == OP_UPDATE) begin
          ram_wdata.actual_delta    = da_upd;
          ram_wdata.reference_delta = dr_upd;
          state_next = ST_MUL0;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_QUOT;
      ST_QUOT: begin
        if (step == STEP_W'(QUOT_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // entries read as zero until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= samples.operation;
      cpu_q  <= samples.cpu_index;
      addr_q <= raddr;
      act_q  <= samples.actual_count;
      ref_q  <= samples.reference_count;
      hit    <= cpu_ok && entry_valid[raddr];
    end
  end

  // one 32-bit half per multiply step
  assign mul_a = (state == ST_MUL1) ? da_q[COUNT_W-1:HALF_W] : da_q[HALF_W-1:0];
  assign mul_d = (state == ST_MUL1) ? dr_q[COUNT_W-1:HALF_W] : dr_q[HALF_W-1:0];
  assign pa    = (HALF_W+SCALE_W)'(mul_a) * (HALF_W+SCALE_W)'(scale_st.value);
  assign pd    = (HALF_W+FREQ_DIV_W)'(mul_d) * (HALF_W+FREQ_DIV_W)'(FREQ_DIV);
  assign ge    = (DV_W'(rem) >= dv);

  always_ff @(posedge clk) begin
    case (state)
      ST_UPDATE: begin
        da_q <= da_upd;
        dr_q <= dr_upd;
      end
      ST_MUL0: begin
        prod <= PROD_W'(pa);
        den  <= DEN_W'(pd);
      end
      ST_MUL1: begin
        // first quotient step tests quotient >= 2^20, i.e. saturation
        rem  <= prod + (PROD_W'(pa) << HALF_W);
        dv   <= DV_W'(den + (DEN_W'(pd) << HALF_W)) << FREQ_W;
        step <= '0;
      end
      ST_QUOT: begin
        if (ge) begin
          rem <= rem - PROD_W'(dv);
        end
        q    <= {q[QUOT_STEPS-2:0], ge};
        dv   <= dv >> 1;
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_cpu  <= cpu_q;
      out_freq <= q[QUOT_STEPS-1] ? '1 : q[FREQ_W-1:0];
      out_sat  <= q[QUOT_STEPS-1];
    end
  end

  assign result.valid     = out_valid;
  assign result.cpu_out   = out_cpu;
  assign result.freq_mhz  = out_freq;
  assign result.saturated = out_sat;

  a_ref_delta_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && op_q == OP_UPDATE) |-> ram_wdata.reference_delta != '0)
    else $error("zero reference delta written back");

  a_quot_steps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QUOT) |-> step < STEP_W'(QUOT_STEPS))
    else $error("quotient step count overrun");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside result load");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> !$past(accept) || $past(state) == ST_IDLE)
    else $error("word accepted while busy");

endmodule
